@@ src/cnm_pkg.sv @@
// shared types, constants and codes of the nrom cartridge memory block
package cnm_pkg;

    localparam int PRG_BANK_BYTES    = 16384;
    localparam int PRG_BANK_BITS     = 14;
    localparam int MAX_PRG_BANKS_DEF = 2;
    localparam int CHR_BYTES         = 8192;
    localparam int CHR_BITS          = 13;
    localparam int WRAM_BYTES        = 8192;
    localparam int WRAM_BITS         = 13;
    localparam int TRAINER_BYTES     = 512;
    localparam int HDR_LEN           = 16;
    localparam int HDR_BITS          = 4;
    localparam int CNT_W             = 17;
    localparam int ENT_ADDR_W        = 15;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = 17'h1FFFF;
    localparam logic [15:0] CPU_PRG_BASE   = 16'h8000;
    localparam logic [15:0] CPU_WRAM_BASE  = 16'h6000;
    localparam logic [7:0]  MAGIC_0        = 8'h4E;
    localparam logic [7:0]  MAGIC_1        = 8'h45;
    localparam logic [7:0]  MAGIC_2        = 8'h53;
    localparam logic [7:0]  MAGIC_3        = 8'h1A;
    localparam logic [71:0] DD_TAG         = "DiskDude!";

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        REQ_IMAGE  = 3'd0,
        REQ_CPU_RD = 3'd1,
        REQ_CPU_WR = 3'd2,
        REQ_PPU_RD = 3'd3,
        REQ_PPU_WR = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_MAGIC  = 3'd2,
        ST_MAPPER = 3'd3,
        ST_SIZE   = 3'd4,
        ST_TRUNC  = 3'd5
    } load_status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PRG_WR,
        OP_PRG_RD,
        OP_WRAM_WR,
        OP_WRAM_RD,
        OP_CHR_WR,
        OP_CHR_RD,
        OP_ZERO_RD
    } mem_op_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_PRG,
        SRC_CHR,
        SRC_WRAM
    } src_t;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        mem_op_t               op;
        logic [ENT_ADDR_W-1:0] addr;
        logic [7:0]            data;
        logic                  status;
        load_status_t          load_status;
        logic [1:0]            mirror;
        logic                  clear_first;
    } entry_t;

endpackage

@@ src/cnm_front.sv @@
// front part: accepts words, tracks the image header and classifies each request
module cnm_front #(
    parameter int MAX_PRG_BANKS = cnm_pkg::MAX_PRG_BANKS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [23:0]     s_tdata,
    input  logic [2:0]      s_tuser,
    input  logic            s_tlast,
    input  logic            q_full,
    output logic            q_push,
    output cnm_pkg::entry_t q_entry
);
    import cnm_pkg::*;

    localparam int PRG_W = $clog2(MAX_PRG_BANKS * PRG_BANK_BYTES);

    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       hdr_next [HDR_LEN];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [1:0]       prg_banks_reg;
    logic [1:0]       prg_banks_next;

    logic [15:0]      addr;
    logic [7:0]       byte_in;
    logic             accept;
    logic             is_hdr_pos;
    logic [CNT_W-1:0] tr_len;
    logic [CNT_W-1:0] body_base;
    logic [CNT_W-1:0] off;
    logic             in_body;
    logic             prg_ok;
    logic [CNT_W-1:0] prg_len;
    logic [CNT_W-1:0] chr_off;
    logic [CNT_W-1:0] chr_len;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] need;
    logic             tag_ok;
    logic             magic_bad;
    logic             mapper_bad;
    load_status_t     st;
    logic [1:0]       mirror;
    logic [PRG_W-1:0] prg_mask;
    logic [PRG_W-1:0] cpu_prg_idx;
    entry_t           ent;

    assign addr     = s_tdata[15:0];
    assign byte_in  = s_tdata[23:16];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // header as it stands after this byte
    always_comb
    begin
        is_hdr_pos = cnt_reg < CNT_W'(HDR_LEN);
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_next[i] = (cnt_reg == '0) ? 8'h00 : hdr_reg[i];
            if (is_hdr_pos && cnt_reg[HDR_BITS-1:0] == HDR_BITS'(i))
            begin
                hdr_next[i] = byte_in;
            end
        end
    end

    always_comb
    begin
        tr_len    = hdr_next[6][2] ? CNT_W'(TRAINER_BYTES) : '0;
        body_base = CNT_W'(HDR_LEN) + tr_len;
        off       = cnt_reg - body_base;
        in_body   = cnt_reg >= body_base;
        prg_ok    = (hdr_next[4] != 8'd0) && (hdr_next[4] <= 8'(MAX_PRG_BANKS));
        prg_len   = CNT_W'(hdr_next[4][1:0]) << PRG_BANK_BITS;
        chr_off   = off - prg_len;
        chr_len   = hdr_next[5][0] ? CNT_W'(CHR_BYTES) : '0;
        cnt_inc   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
        need      = body_base + prg_len + chr_len;
        mirror    = {hdr_next[6][3], hdr_next[6][0]};

        tag_ok = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            if (hdr_next[7 + i] != DD_TAG[71 - 8 * i -: 8])
            begin
                tag_ok = 1'b0;
            end
        end

        magic_bad  = (hdr_next[0] != MAGIC_0) || (hdr_next[1] != MAGIC_1) ||
                     (hdr_next[2] != MAGIC_2) || (hdr_next[3] != MAGIC_3);
        mapper_bad = (hdr_next[6][7:4] != 4'd0) || (!tag_ok && hdr_next[7][7:4] != 4'd0);

        if (cnt_inc < CNT_W'(HDR_LEN))
            st = ST_SHORT;
        else if (magic_bad)
            st = ST_MAGIC;
        else if (mapper_bad)
            st = ST_MAPPER;
        else if (!prg_ok || hdr_next[5] > 8'd1)
            st = ST_SIZE;
        else if (cnt_inc < need)
            st = ST_TRUNC;
        else
            st = ST_OK;
    end

    // cpu side prg mirroring
    always_comb
    begin
        prg_mask    = (prg_banks_reg == 2'd1) ? PRG_W'(PRG_BANK_BYTES - 1) : '1;
        cpu_prg_idx = addr[PRG_W-1:0] & prg_mask;
    end

    always_comb
    begin
        ent             = '0;
        ent.op          = OP_NONE;
        ent.data        = byte_in;
        ent.load_status = ST_OK;
        case (s_tuser)
            REQ_IMAGE:
            begin
                ent.clear_first = (cnt_reg == '0);
                if (s_tlast)
                begin
                    ent.status      = 1'b1;
                    ent.load_status = st;
                    ent.mirror      = mirror;
                end
                if (!is_hdr_pos && in_body && prg_ok)
                begin
                    if (off < prg_len)
                    begin
                        ent.op   = OP_PRG_WR;
                        ent.addr = ENT_ADDR_W'(off[PRG_W-1:0]);
                    end
                    else if (hdr_next[5] == 8'd1 && chr_off < CNT_W'(CHR_BYTES))
                    begin
                        ent.op   = OP_CHR_WR;
                        ent.addr = ENT_ADDR_W'(chr_off[CHR_BITS-1:0]);
                    end
                end
            end
            REQ_CPU_RD:
            begin
                if (addr >= CPU_PRG_BASE)
                begin
                    ent.op   = OP_PRG_RD;
                    ent.addr = ENT_ADDR_W'(cpu_prg_idx);
                end
                else if (addr >= CPU_WRAM_BASE)
                begin
                    ent.op   = OP_WRAM_RD;
                    ent.addr = ENT_ADDR_W'(addr[WRAM_BITS-1:0]);
                end
                else
                begin
                    ent.op = OP_ZERO_RD;
                end
            end
            REQ_CPU_WR:
            begin
                if (addr >= CPU_PRG_BASE)
                begin
                    ent.op   = OP_PRG_WR;
                    ent.addr = ENT_ADDR_W'(cpu_prg_idx);
                end
                else if (addr >= CPU_WRAM_BASE)
                begin
                    ent.op   = OP_WRAM_WR;
                    ent.addr = ENT_ADDR_W'(addr[WRAM_BITS-1:0]);
                end
            end
            REQ_PPU_RD:
            begin
                ent.op   = OP_CHR_RD;
                ent.addr = ENT_ADDR_W'(addr[CHR_BITS-1:0]);
            end
            REQ_PPU_WR:
            begin
                ent.op   = OP_CHR_WR;
                ent.addr = ENT_ADDR_W'(addr[CHR_BITS-1:0]);
            end
            default:
            begin
                ent.op = OP_NONE;
            end
        endcase
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.op != OP_NONE || ent.status || ent.clear_first);

    always_comb
    begin
        cnt_next       = cnt_reg;
        prg_banks_next = prg_banks_reg;
        if (accept && s_tuser == REQ_IMAGE)
        begin
            cnt_next = s_tlast ? '0 : cnt_inc;
            if (s_tlast && st == ST_OK)
            begin
                prg_banks_next = hdr_next[4][1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            prg_banks_reg <= 2'd1;
            for (int i = 0; i < HDR_LEN; i++)
            begin
                hdr_reg[i] <= 8'h00;
            end
        end
        else
        begin
            cnt_reg       <= cnt_next;
            prg_banks_reg <= prg_banks_next;
            if (accept && s_tuser == REQ_IMAGE)
            begin
                for (int i = 0; i < HDR_LEN; i++)
                begin
                    hdr_reg[i] <= hdr_next[i];
                end
            end
        end
    end

endmodule

@@ src/cnm_queue.sv @@
// short queue of classified requests between front and back
module cnm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cnm_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output cnm_pkg::entry_t head
);
    import cnm_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg;
    logic [QPTR_W:0]   cnt_next;

    assign full  = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/cnm_back.sv @@
// back part: prg, chr and work ram stores, clearing sweep and result register
module cnm_back #(
    parameter int MAX_PRG_BANKS = cnm_pkg::MAX_PRG_BANKS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cnm_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,   // read_data, load_status, mirror_mode, 3'b0
    output logic [0:0]      m_tuser    // result_kind
);
    import cnm_pkg::*;

    localparam int PRG_DEPTH = MAX_PRG_BANKS * PRG_BANK_BYTES;
    localparam int PRG_W     = $clog2(PRG_DEPTH);

    logic [7:0] prg_mem  [PRG_DEPTH];
    logic [7:0] chr_mem  [CHR_BYTES];
    logic [7:0] wram_mem [WRAM_BYTES];

    logic [7:0] prg_rd_reg;
    logic [7:0] chr_rd_reg;
    logic [7:0] wram_rd_reg;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [WRAM_BITS-1:0] clr_cnt_reg;
    logic [WRAM_BITS-1:0] clr_cnt_next;
    logic                 cleared_reg;
    logic                 cleared_next;
    logic                 clr_we;

    logic         res_valid_reg;
    logic         res_valid_next;
    logic         res_kind_reg;
    logic         res_kind_next;
    src_t         res_src_reg;
    src_t         res_src_next;
    load_status_t res_status_reg;
    load_status_t res_status_next;
    logic [1:0]   res_mirror_reg;
    logic [1:0]   res_mirror_next;
    logic         res_free;
    logic         is_read;
    logic [7:0]   rd_byte;

    assign res_free = !res_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cleared_next = cleared_reg;
        q_pop        = 1'b0;
        clr_we       = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + WRAM_BITS'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next   = BK_RUN;
                    cleared_next = q_valid && q_head.clear_first;
                end
            end
            BK_RUN:
            begin
                if (q_valid && q_head.clear_first && !cleared_reg)
                begin
                    state_next = BK_CLEAR;
                end
                else if (q_valid && res_free)
                begin
                    q_pop        = 1'b1;
                    cleared_next = 1'b0;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
            cleared_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cleared_reg <= cleared_next;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.op == OP_PRG_WR)
        begin
            prg_mem[q_head.addr[PRG_W-1:0]] <= q_head.data;
        end
        if (q_pop && q_head.op == OP_PRG_RD)
        begin
            prg_rd_reg <= prg_mem[q_head.addr[PRG_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            chr_mem[clr_cnt_reg] <= 8'h00;
        end
        else if (q_pop && q_head.op == OP_CHR_WR)
        begin
            chr_mem[q_head.addr[CHR_BITS-1:0]] <= q_head.data;
        end
        if (q_pop && q_head.op == OP_CHR_RD)
        begin
            chr_rd_reg <= chr_mem[q_head.addr[CHR_BITS-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            wram_mem[clr_cnt_reg] <= 8'h00;
        end
        else if (q_pop && q_head.op == OP_WRAM_WR)
        begin
            wram_mem[q_head.addr[WRAM_BITS-1:0]] <= q_head.data;
        end
        if (q_pop && q_head.op == OP_WRAM_RD)
        begin
            wram_rd_reg <= wram_mem[q_head.addr[WRAM_BITS-1:0]];
        end
    end

    // result register
    always_comb
    begin
        is_read = (q_head.op == OP_PRG_RD) || (q_head.op == OP_CHR_RD) ||
                  (q_head.op == OP_WRAM_RD) || (q_head.op == OP_ZERO_RD);

        res_valid_next  = res_valid_reg;
        res_kind_next   = res_kind_reg;
        res_src_next    = res_src_reg;
        res_status_next = res_status_reg;
        res_mirror_next = res_mirror_reg;
        if (res_free)
        begin
            res_valid_next  = q_pop && (is_read || q_head.status);
            res_kind_next   = q_head.status ? KIND_STATUS : KIND_READ;
            res_status_next = q_head.status ? q_head.load_status : ST_OK;
            res_mirror_next = q_head.status ? q_head.mirror : 2'd0;
            case (q_head.op)
                OP_PRG_RD:  res_src_next = SRC_PRG;
                OP_CHR_RD:  res_src_next = SRC_CHR;
                OP_WRAM_RD: res_src_next = SRC_WRAM;
                default:    res_src_next = SRC_ZERO;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg   <= res_kind_next;
        res_src_reg    <= res_src_next;
        res_status_reg <= res_status_next;
        res_mirror_reg <= res_mirror_next;
    end

    always_comb
    begin
        case (res_src_reg)
            SRC_PRG:  rd_byte = prg_rd_reg;
            SRC_CHR:  rd_byte = chr_rd_reg;
            SRC_WRAM: rd_byte = wram_rd_reg;
            default:  rd_byte = 8'h00;
        endcase
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {3'b000, res_mirror_reg, res_status_reg, rd_byte};
    assign m_tuser  = res_kind_reg;

endmodule

@@ src/ines_cartridge_nrom_memory.sv @@
// top level of the nrom cartridge memory with ines image loader
//
// input stream: one word per request; tuser selects image byte, cpu read,
// cpu write, ppu read or ppu write; tdata carries the address and data byte;
// tlast marks the final byte of an image
// output stream: one word per read, holding the byte, and one word per
// final image byte, holding the load status and mirroring mode
// throughput: one word per cycle on both sides while neither the sweep nor the receiver holds the flow
// path: an accepted word is registered in the queue, then popped into the stores, and a
// read result is registered in the result register before m_tvalid rises
// rate limit: the clearing sweep of chr and work ram, one address a cycle over
// all 8192 addresses, runs after reset and again when the first byte of each
// image reaches the stores; the front keeps taking words until the 4-entry
// queue fills, then holds s_tready low
// reset: counters and header cleared, one prg bank, then the sweep runs
// receiver stall: the result register holds, the stores stop issuing,
// the queue fills and s_tready drops
module ines_cartridge_nrom_memory #(
    parameter int MAX_PRG_BANKS = cnm_pkg::MAX_PRG_BANKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address, data
    input  logic [2:0]  s_tuser,   // req_type
    input  logic        s_tlast,   // image_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data, load_status, mirror_mode, 3'b0
    output logic [0:0]  m_tuser    // result_kind
);
    import cnm_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_valid;
    entry_t q_entry;
    entry_t q_head;

    cnm_front #(
        .MAX_PRG_BANKS (MAX_PRG_BANKS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    cnm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .valid      (q_valid),
        .head       (q_head)
    );

    cnm_back #(
        .MAX_PRG_BANKS (MAX_PRG_BANKS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == KIND_STATUS) |-> (m_tdata[7:0] == 8'h00))
        else $error("status word carries a data byte");

    a_read_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == KIND_READ) |-> (m_tdata[12:8] == 5'd0))
        else $error("read word carries status or mirroring");

endmodule
